>>> src/deq_pkg.sv
`timescale 1ns / 1ps

package deq_pkg;

   localparam int MODE_W   = 3;
   localparam int INDEX_W  = 10;
   localparam int VALUE_W  = 32;
   localparam int SIZE_W   = 11;
   localparam int STATUS_W = 2;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH_FRONT = 3'd0,
      MODE_PUSH_BACK  = 3'd1,
      MODE_READ       = 3'd2,
      MODE_WRITE      = 3'd3,
      MODE_CLEAR      = 3'd4
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_RANGE     = 2'd1,
      STATUS_FULL      = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_LOAD = 1'b1
   } state_type;

endpackage

>>> src/double_ended_queue_store.sv
// A request is accepted only in ST_IDLE; it then passes to ST_LOAD, which
// loads its result into the registered response outputs once they are free.
// No new request is accepted until that load, so requests are taken one at a
// time; ST_LOAD waits on the registered read of the ring memory.
// Reset clears the front pointer, the count and the handshake state. The
// ring memory is not cleared; only entries written by a push are read.
`timescale 1ns / 1ps

module double_ended_queue_store #(
   parameter int CAPACITY   = 1024,
   parameter int DATA_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [deq_pkg::MODE_W-1:0]           req_mode,
   input  logic [deq_pkg::INDEX_W-1:0]          req_index,
   input  logic signed [deq_pkg::VALUE_W-1:0]   req_value,

   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [deq_pkg::VALUE_W-1:0]   rsp_read_value,
   output logic [deq_pkg::SIZE_W-1:0]           rsp_size,
   output logic                                 rsp_is_empty,
   output logic signed [deq_pkg::VALUE_W-1:0]   rsp_front_value,
   output logic signed [deq_pkg::VALUE_W-1:0]   rsp_back_value,
   output logic [deq_pkg::STATUS_W-1:0]         rsp_status
);

   import deq_pkg::*;

   localparam int PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
   localparam logic [PTR_W:0]   CAP_SUM = (PTR_W + 1)'(CAPACITY);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(CAPACITY - 1);

   logic signed [DATA_WIDTH-1:0] ring_mem [CAPACITY];

   state_type                    state_ff, state_in;
   logic [PTR_W-1:0]             front_ptr_ff, front_ptr_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic signed [DATA_WIDTH-1:0] front_val_ff, front_val_in;
   logic signed [DATA_WIDTH-1:0] back_val_ff, back_val_in;
   status_type                   status_ff, status_in;
   logic                         rd_hit_ff, rd_hit_in;
   logic signed [DATA_WIDTH-1:0] rd_data_ff;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0]    rsp_read_value_ff, rsp_read_value_in;
   logic [SIZE_W-1:0]            rsp_size_ff, rsp_size_in;
   logic                         rsp_is_empty_ff, rsp_is_empty_in;
   logic signed [VALUE_W-1:0]    rsp_front_value_ff, rsp_front_value_in;
   logic signed [VALUE_W-1:0]    rsp_back_value_ff, rsp_back_value_in;
   logic [STATUS_W-1:0]          rsp_status_ff, rsp_status_in;

   logic                         accept;
   logic                         load;
   logic                         full;
   logic                         empty;
   logic                         idx_ok;
   logic [CMP_W-1:0]             idx_cmp;
   logic [CMP_W-1:0]             cnt_cmp;
   logic [PTR_W-1:0]             logical;
   logic [PTR_W:0]               slot_sum;
   logic [PTR_W-1:0]             slot;
   logic [PTR_W-1:0]             mem_addr;
   logic                         mem_we;
   logic                         mem_re;
   logic signed [63:0]           value_wide;
   logic signed [DATA_WIDTH-1:0] store_val;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign full      = (count_ff == CAP_CNT);
   assign empty     = (count_ff == '0);
   assign idx_cmp   = CMP_W'(req_index);
   assign cnt_cmp   = CMP_W'(count_ff);
   assign idx_ok    = (idx_cmp < cnt_cmp);
   assign value_wide = 64'(req_value);
   assign store_val  = value_wide[DATA_WIDTH-1:0];

   always_comb begin
      logical = idx_cmp[PTR_W-1:0];
      if (mode_type'(req_mode) == MODE_PUSH_BACK) begin
         logical = count_ff[PTR_W-1:0];
      end
      slot_sum = {1'b0, front_ptr_ff} + {1'b0, logical};
      if (slot_sum >= CAP_SUM) begin
         slot_sum = slot_sum - CAP_SUM;
      end
      slot = slot_sum[PTR_W-1:0];
   end

   always_comb begin
      state_in     = state_ff;
      front_ptr_in = front_ptr_ff;
      count_in     = count_ff;
      front_val_in = front_val_ff;
      back_val_in  = back_val_ff;
      status_in    = status_ff;
      rd_hit_in    = rd_hit_ff;
      mem_addr     = slot;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      load         = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in  = ST_LOAD;
               status_in = STATUS_OK;
               rd_hit_in = 1'b0;
               unique case (req_mode)
                  MODE_PUSH_FRONT: begin
                     if (full) begin
                        status_in = STATUS_FULL;
                     end else begin
                        mem_addr     = (front_ptr_ff == '0) ? LAST_SLOT
                                                            : front_ptr_ff - 1'b1;
                        mem_we       = 1'b1;
                        front_ptr_in = mem_addr;
                        count_in     = count_ff + 1'b1;
                        front_val_in = store_val;
                        if (empty) begin
                           back_val_in = store_val;
                        end
                     end
                  end
                  MODE_PUSH_BACK: begin
                     if (full) begin
                        status_in = STATUS_FULL;
                     end else begin
                        mem_we      = 1'b1;
                        count_in    = count_ff + 1'b1;
                        back_val_in = store_val;
                        if (empty) begin
                           front_val_in = store_val;
                        end
                     end
                  end
                  MODE_READ: begin
                     if (!idx_ok) begin
                        status_in = STATUS_RANGE;
                     end else begin
                        mem_re    = 1'b1;
                        rd_hit_in = 1'b1;
                     end
                  end
                  MODE_WRITE: begin
                     if (!idx_ok) begin
                        status_in = STATUS_RANGE;
                     end else begin
                        mem_we = 1'b1;
                        if (idx_cmp == '0) begin
                           front_val_in = store_val;
                        end
                        if (idx_cmp == cnt_cmp - 1'b1) begin
                           back_val_in = store_val;
                        end
                     end
                  end
                  MODE_CLEAR: begin
                     count_in     = '0;
                     front_ptr_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LOAD: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in       = rsp_valid_ff && !rsp_ready;
      rsp_read_value_in  = rsp_read_value_ff;
      rsp_size_in        = rsp_size_ff;
      rsp_is_empty_in    = rsp_is_empty_ff;
      rsp_front_value_in = rsp_front_value_ff;
      rsp_back_value_in  = rsp_back_value_ff;
      rsp_status_in      = rsp_status_ff;
      if (load) begin
         rsp_valid_in       = 1'b1;
         rsp_read_value_in  = rd_hit_ff ? VALUE_W'(rd_data_ff) : '0;
         rsp_size_in        = SIZE_W'(count_ff);
         rsp_is_empty_in    = empty;
         rsp_front_value_in = empty ? '0 : VALUE_W'(front_val_ff);
         rsp_back_value_in  = empty ? '0 : VALUE_W'(back_val_ff);
         rsp_status_in      = status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_ptr_ff <= '0;
         count_ff     <= '0;
         rd_hit_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ptr_ff <= front_ptr_in;
         count_ff     <= count_in;
         rd_hit_ff    <= rd_hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      front_val_ff       <= front_val_in;
      back_val_ff        <= back_val_in;
      status_ff          <= status_in;
      rsp_read_value_ff  <= rsp_read_value_in;
      rsp_size_ff        <= rsp_size_in;
      rsp_is_empty_ff    <= rsp_is_empty_in;
      rsp_front_value_ff <= rsp_front_value_in;
      rsp_back_value_ff  <= rsp_back_value_in;
      rsp_status_ff      <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_addr] <= store_val;
      end
      if (mem_re) begin
         rd_data_ff <= ring_mem[mem_addr];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_size        = rsp_size_ff;
   assign rsp_is_empty    = rsp_is_empty_ff;
   assign rsp_front_value = rsp_front_value_ff;
   assign rsp_back_value  = rsp_back_value_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

>>> tb/sv/tb_double_ended_queue_store.sv
`timescale 1ns / 1ps

module tb_double_ended_queue_store;
   import deq_pkg::*;

   localparam int CAPACITY     = 1024;
   localparam int DATA_WIDTH   = 32;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam int REPORT_LIMIT = 10;

   localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
   localparam logic [MODE_W-1:0] MODE_SPARE_MID   = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;

   typedef struct packed {
      logic signed [VALUE_W-1:0] read_value;
      logic [SIZE_W-1:0]         size;
      logic                      is_empty;
      logic signed [VALUE_W-1:0] front_value;
      logic signed [VALUE_W-1:0] back_value;
      logic [STATUS_W-1:0]       status;
   } deq_result_type;

   class deq_scoreboard_type;
      logic [VALUE_W-1:0] ring [CAPACITY];
      int unsigned        head;
      int unsigned        count;
      deq_result_type     expected_q [$];
      int unsigned        mismatches;
      int unsigned        checked;
      int unsigned        peak_count;
      int unsigned        refused_pushes;
      int unsigned        range_errors;
      int unsigned        mode_hits [8];

      function new();
         foreach (ring[i]) ring[i] = '0;
         foreach (mode_hits[i]) mode_hits[i] = 0;
         head = 0;
         count = 0;
         mismatches = 0;
         checked = 0;
         peak_count = 0;
         refused_pushes = 0;
         range_errors = 0;
      endfunction

      function int unsigned ring_slot(int unsigned logical);
         return (head + logical) % CAPACITY;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function void note_request(logic [MODE_W-1:0] mode, logic [INDEX_W-1:0] idx,
                                 logic [VALUE_W-1:0] value);
         deq_result_type r;
         r = '0;
         mode_hits[mode]++;
         case (mode)
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
               if (count >= CAPACITY) begin
                  r.status = STATUS_FULL;
                  refused_pushes++;
               end else if (mode == MODE_PUSH_FRONT) begin
                  head = (head + CAPACITY - 1) % CAPACITY;
                  ring[head] = value;
                  count++;
               end else begin
                  ring[ring_slot(count)] = value;
                  count++;
               end
            end
            MODE_READ, MODE_WRITE: begin
               if (idx >= count) begin
                  r.status = STATUS_RANGE;
                  range_errors++;
               end else if (mode == MODE_READ) begin
                  r.read_value = ring[ring_slot(idx)];
               end else begin
                  ring[ring_slot(idx)] = value;
               end
            end
            MODE_CLEAR: begin
               count = 0;
               head = 0;
            end
            default: begin
            end
         endcase
         if (count > peak_count) peak_count = count;
         r.size = SIZE_W'(count);
         r.is_empty = (count == 0);
         if (count != 0) begin
            r.front_value = ring[ring_slot(0)];
            r.back_value = ring[ring_slot(count - 1)];
         end
         expected_q.insert(expected_q.size(), r);
      endfunction

      function void check_response(deq_result_type got);
         deq_result_type want;
         string          bad;
         bad = "";
         checked++;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("[%0t] unexpected response, nothing pending: %p", $time, got);
            return;
         end
         want = expected_q.pop_front();
         if (got.read_value !== want.read_value) bad = {bad, " read_value"};
         if (got.size !== want.size) bad = {bad, " size"};
         if (got.is_empty !== want.is_empty) bad = {bad, " is_empty"};
         if (got.front_value !== want.front_value) bad = {bad, " front_value"};
         if (got.back_value !== want.back_value) bad = {bad, " back_value"};
         if (got.status !== want.status) bad = {bad, " status"};
         if (bad != "") begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("[%0t] response %0d mismatch in%s", $time, checked, bad);
               $display("   expected rd=%h size=%0d empty=%b front=%h back=%h status=%0d",
                        want.read_value, want.size, want.is_empty, want.front_value,
                        want.back_value, want.status);
               $display("   actual   rd=%h size=%0d empty=%b front=%h back=%h status=%0d",
                        got.read_value, got.size, got.is_empty, got.front_value,
                        got.back_value, got.status);
            end
         end
      endfunction
   endclass

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [MODE_W-1:0]         req_mode = '0;
   logic [INDEX_W-1:0]        req_index = '0;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [VALUE_W-1:0] rsp_read_value;
   logic [SIZE_W-1:0]         rsp_size;
   logic                      rsp_is_empty;
   logic signed [VALUE_W-1:0] rsp_front_value;
   logic signed [VALUE_W-1:0] rsp_back_value;
   logic [STATUS_W-1:0]       rsp_status;

   deq_scoreboard_type sb;
   deq_result_type     seen;
   int                 burst_left = 0;
   int                 stall_kind = 0;
   int                 stall_left = 0;
   int                 stall_tick = 0;
   int                 idle_cycles = 0;

   double_ended_queue_store #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_index       (req_index),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_read_value  (rsp_read_value),
      .rsp_size        (rsp_size),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_front_value (rsp_front_value),
      .rsp_back_value  (rsp_back_value),
      .rsp_status      (rsp_status)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // The receiver moves between always-ready, random, periodic and long-stall phases.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen.read_value = rsp_read_value;
            seen.size = rsp_size;
            seen.is_empty = rsp_is_empty;
            seen.front_value = rsp_front_value;
            seen.back_value = rsp_back_value;
            seen.status = rsp_status;
            sb.check_response(seen);
         end
         if (stall_left == 0) begin
            stall_kind = $urandom_range(0, 3);
            stall_left = (stall_kind == 3) ? $urandom_range(5, 30) : $urandom_range(10, 80);
         end
         stall_left--;
         stall_tick++;
         case (stall_kind)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            2: rsp_ready <= (stall_tick % 3 == 0);
            default: rsp_ready <= 1'b0;
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("[%0t] no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("** double_ended_queue_store: FAILED **");
            $finish;
         end
      end
   end

   task automatic send_request(input logic [MODE_W-1:0] mode, input logic [INDEX_W-1:0] idx,
                               input logic [VALUE_W-1:0] value);
      req_valid <= 1'b1;
      req_mode <= mode;
      req_index <= idx;
      req_value <= value;
      do @(posedge clock); while (!(req_valid && req_ready));
      sb.note_request(mode, idx, value);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                  : $urandom_range(0, 10);
      end
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   function automatic logic [INDEX_W-1:0] pick_index();
      if (sb.count > 0 && $urandom_range(0, 3) != 0)
         return INDEX_W'($urandom_range(0, sb.count - 1));
      return INDEX_W'($urandom_range(0, CAPACITY - 1));
   endfunction

   task automatic send_random_request();
      int unsigned roll;
      logic [MODE_W-1:0] mode;
      roll = $urandom_range(0, 99);
      if (roll < 22) mode = MODE_PUSH_FRONT;
      else if (roll < 44) mode = MODE_PUSH_BACK;
      else if (roll < 68) mode = MODE_READ;
      else if (roll < 88) mode = MODE_WRITE;
      else if (roll < 93) mode = MODE_CLEAR;
      else mode = MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
      send_request(mode, pick_index(), $urandom);
   endtask

   task automatic fill_to_capacity();
      int unsigned roll;
      while (sb.count < CAPACITY) begin
         roll = $urandom_range(0, 19);
         if (roll == 0 && sb.count > 0)
            send_request(MODE_READ, INDEX_W'($urandom_range(0, sb.count - 1)), $urandom);
         else if (roll == 1 && sb.count > 0)
            send_request(MODE_WRITE, INDEX_W'($urandom_range(0, sb.count - 1)), $urandom);
         else if (roll[0])
            send_request(MODE_PUSH_FRONT, pick_index(), $urandom);
         else
            send_request(MODE_PUSH_BACK, pick_index(), $urandom);
      end
   endtask

   initial begin
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(MODE_READ, '0, 32'h1111_1111);
      send_request(MODE_WRITE, '0, 32'h2222_2222);
      send_request(MODE_SPARE_FIRST, '1, '1);
      send_request(MODE_SPARE_LAST, '0, '0);
      send_request(MODE_PUSH_BACK, '0, 32'h7FFF_FFFF);
      send_request(MODE_PUSH_FRONT, '1, 32'h8000_0000);
      send_request(MODE_PUSH_BACK, '0, 32'hFFFF_FFFF);
      send_request(MODE_PUSH_FRONT, '0, 32'h0000_0000);
      send_request(MODE_READ, 10'd0, '0);
      send_request(MODE_READ, 10'd1, '0);
      send_request(MODE_READ, 10'd2, '0);
      send_request(MODE_READ, 10'd3, '0);
      send_request(MODE_READ, 10'd4, '0);
      send_request(MODE_READ, '1, '0);
      send_request(MODE_WRITE, 10'd3, 32'h1234_5678);
      send_request(MODE_WRITE, 10'd4, 32'hDEAD_BEEF);
      send_request(MODE_READ, 10'd3, '0);
      send_request(MODE_SPARE_MID, 10'd2, 32'h5555_5555);
      send_request(MODE_CLEAR, '1, '1);
      send_request(MODE_READ, 10'd0, '0);
      send_request(MODE_PUSH_BACK, '0, 32'hFFFF_FFFF);
      send_request(MODE_CLEAR, '0, '0);
      wait_until_drained();

      repeat (200) send_random_request();
      wait_until_drained();

      fill_to_capacity();
      send_request(MODE_PUSH_FRONT, '0, $urandom);
      send_request(MODE_PUSH_BACK, '1, $urandom);
      send_request(MODE_PUSH_FRONT, '1, $urandom);
      send_request(MODE_PUSH_BACK, '0, $urandom);
      send_request(MODE_READ, '0, '0);
      send_request(MODE_READ, '1, '0);
      send_request(MODE_WRITE, '1, 32'h8000_0001);
      send_request(MODE_WRITE, '0, 32'h7FFF_FFFE);
      send_request(MODE_READ, '1, '0);
      send_request(MODE_SPARE_LAST, '1, '1);
      repeat (6) send_request(MODE_READ, INDEX_W'($urandom), '0);
      send_request(MODE_CLEAR, '0, '0);

      repeat (30) send_random_request();

      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d requests (%0d push front, %0d push back, %0d read, %0d write, %0d clear)",
               sb.checked, sb.mode_hits[MODE_PUSH_FRONT], sb.mode_hits[MODE_PUSH_BACK],
               sb.mode_hits[MODE_READ], sb.mode_hits[MODE_WRITE], sb.mode_hits[MODE_CLEAR]);
      $display("Peak size %0d, %0d pushes refused when full, %0d accesses out of range",
               sb.peak_count, sb.refused_pushes, sb.range_errors);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("** double_ended_queue_store: PASSED **");
      end else begin
         $display("%0d mismatches, %0d responses missing", sb.mismatches, sb.pending());
         $display("** double_ended_queue_store: FAILED **");
      end
      $finish;
   end

endmodule
